FILE: src/crc_scheme_detector_assert.svh
// Assertion macros for the CRC scheme detector.
// Used by the checker module; no other dependencies.
`ifndef CRC_SCHEME_DETECTOR_ASSERT_SVH
`define CRC_SCHEME_DETECTOR_ASSERT_SVH
// Implication checked at every clock edge, off during reset.
`define CSD_ASSERT_IMP(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
// Next-cycle implication, off during reset.
`define CSD_ASSERT_NEXT(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`endif

FILE: src/csd_pkg.sv
// Package for the CRC scheme detector: sizes, op and status codes, scheme table.
// No dependencies.
package csd_pkg;
  localparam int unsigned MaxFramesDef = 64;
  localparam int unsigned MaxBytesDef  = 64;
  localparam int unsigned NumSchemes   = 7;
  localparam int unsigned MinFrames    = 5;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_ADD    = 2'd1;
  localparam logic [1:0] OP_SEARCH = 2'd2;

  localparam logic [1:0] ST_FOUND   = 2'd0;
  localparam logic [1:0] ST_NONE    = 2'd1;
  localparam logic [1:0] ST_TOO_FEW = 2'd2;

  typedef struct packed {
    logic [15:0] poly;
    logic        wide;   // 16-bit CRC
    logic        valid;  // 32-bit entries never match
    logic [15:0] init;
  } scheme_t;

  function automatic scheme_t scheme_entry(input logic [2:0] idx);
    scheme_t s;
    unique case (idx)
      3'd0, 3'd1: s = '{poly: 16'h0007, wide: 1'b0, valid: 1'b1, init: 16'h0000};
      3'd2, 3'd4: s = '{poly: 16'h8005, wide: 1'b1, valid: 1'b1, init: 16'h0000};
      3'd3:       s = '{poly: 16'h1021, wide: 1'b1, valid: 1'b1, init: 16'hFFFF};
      default:    s = '{poly: 16'h1DB7, wide: 1'b1, valid: 1'b0, init: 16'hFFFF};
    endcase
    return s;
  endfunction
endpackage

FILE: src/csd_ram.sv
// Generic simple dual-port RAM (one write port, one read port) with registered read.
// No dependencies.
module csd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: src/crc_scheme_detector.sv
// CRC scheme detector: stores frames, searches seven CRC schemes on request.
// Clear, add-byte and too-few search words are handled in the idle state; busy stays low for them.
// Search: per scheme and per frame, a length read, then per byte a byte read, and each
//   folded byte is shifted through the CRC bit by bit; frames under 3 bytes are not scanned.
// Busy falls as the one-cycle result strobe rises; the receiver cannot stall.
// Synchronous active-high reset clears counts and sequencer; RAMs keep data.
module crc_scheme_detector
  import csd_pkg::*;
#(
  parameter int unsigned MAX_FRAMES = MaxFramesDef,
  parameter int unsigned MAX_BYTES  = MaxBytesDef
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  op,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        strobe,
  output logic [1:0]  status,
  output logic [2:0]  scheme_index,
  output logic [15:0] found_polynomial,
  output logic [6:0]  frames_matched
);
  localparam int unsigned FW = $clog2(MAX_FRAMES + 1);  // frame count width
  localparam int unsigned FA = $clog2(MAX_FRAMES);      // frame address width
  // length width; at least 3 bits so the tail-window bounds fit
  localparam int unsigned LW = ($clog2(MAX_BYTES + 1) < 3) ? 3 : $clog2(MAX_BYTES + 1);
  localparam int unsigned BA = $clog2(MAX_BYTES);       // byte address width
  localparam int unsigned AW = FA + BA;
  localparam int unsigned TW = FW + 4;                  // frames*10 width

  typedef enum logic [2:0] {
    S_IDLE, S_SCHEME, S_LEN, S_BYTE, S_BIT, S_CHECK, S_FRAMEEND
  } state_t;

  state_t        state;
  logic [FW-1:0] frames_stored;
  logic [LW-1:0] current_length;
  logic [2:0]    sidx;
  logic [FW-1:0] fidx;
  logic [LW-1:0] bidx;       // address of the byte being read; bytes 0..bidx-2 are folded into the CRC
  logic [LW-1:0] flen;
  logic [LW-1:0] lowest;
  logic [15:0]   crc;
  logic [3:0]    bitcnt;
  logic [FW-1:0] count;
  logic          hit;
  logic [15:0]   prev;       // the two bytes most recently read, newest low
  logic [TW-1:0] thr;
  logic [1:0]    rd_wait;

  // Frame byte store and length store.
  logic          bwe, lwe;
  logic [AW-1:0] bwaddr, braddr;
  logic [7:0]    brdata;
  logic [LW-1:0] lrdata;
  logic [FA-1:0] fa_wr, fa_rd;

  assign fa_wr  = frames_stored[FA-1:0];
  assign fa_rd  = fidx[FA-1:0];
  assign bwe    = start && !busy && op == OP_ADD && frames_stored < FW'(MAX_FRAMES)
                  && current_length < LW'(MAX_BYTES);
  assign lwe    = start && !busy && op == OP_ADD && frames_stored < FW'(MAX_FRAMES)
                  && last_byte;
  assign bwaddr = {fa_wr, current_length[BA-1:0]};
  assign braddr = {fa_rd, bidx[BA-1:0]};

  csd_ram #(.Width(8), .Depth(MAX_FRAMES * (2 ** BA))) u_bytes (
    .clk, .we(bwe), .waddr(bwaddr), .wdata(data_byte), .raddr(braddr), .rdata(brdata)
  );

  logic [LW-1:0] lwdata;
  assign lwdata = (current_length < LW'(MAX_BYTES)) ? current_length + 1'b1 : current_length;

  csd_ram #(.Width(LW), .Depth(2 ** FA)) u_lens (
    .clk, .we(lwe), .waddr(fa_wr), .wdata(lwdata), .raddr(fa_rd), .rdata(lrdata)
  );

  scheme_t sch;
  assign sch = scheme_entry(sidx);
  assign busy = (state != S_IDLE);

  // Compare the running CRC against the check bytes read at the current position.
  logic check_ok;
  always_comb begin
    if (sch.wide) check_ok = sch.valid && crc[15:8] == prev[7:0] && crc[7:0] == brdata;
    else          check_ok = sch.valid && crc[7:0] == prev[7:0];
  end

  logic [15:0] crc_step;
  always_comb begin
    if (sch.wide) crc_step = crc[15] ? ((crc << 1) ^ sch.poly) : (crc << 1);
    else crc_step = {8'h00, crc[7] ? ((crc[7:0] << 1) ^ sch.poly[7:0]) : (crc[7:0] << 1)};
  end

  // End-of-frame bookkeeping and the report strobe.
  // thr holds frames*8; count*10 > frames*8 exactly when count exceeds
  // floor(frames*8/10), so no division is needed.
  logic [FW-1:0] cnt_n;
  logic          last_frame;
  logic          over_thr;
  logic          report_fire;
  always_comb begin
    cnt_n       = count + FW'(hit);
    last_frame  = (fidx + 1'b1 >= frames_stored);
    over_thr    = (TW'(cnt_n) * TW'(10)) > thr;
    report_fire = (state == S_IDLE && start && op == OP_SEARCH
                   && frames_stored < FW'(MinFrames))
               || (state == S_FRAMEEND && last_frame
                   && (over_thr || sidx == 3'(NumSchemes - 1)));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      frames_stored  <= '0;
      current_length <= '0;
      strobe         <= 1'b0;
    end else begin
      strobe <= report_fire;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            unique case (op)
              OP_CLEAR: begin
                frames_stored  <= '0;
                current_length <= '0;
              end
              OP_ADD: begin
                if (frames_stored < FW'(MAX_FRAMES)) begin
                  if (last_byte) begin
                    frames_stored  <= frames_stored + 1'b1;
                    current_length <= '0;
                  end else if (current_length < LW'(MAX_BYTES)) begin
                    current_length <= current_length + 1'b1;
                  end
                end else if (last_byte) begin
                  current_length <= '0;
                end
              end
              OP_SEARCH: begin
                if (frames_stored < FW'(MinFrames)) begin
                  status           <= ST_TOO_FEW;
                  scheme_index     <= '0;
                  found_polynomial <= '0;
                  frames_matched   <= '0;
                end else begin
                  thr   <= TW'(frames_stored) << 3;
                  sidx  <= '0;
                  state <= S_SCHEME;
                end
              end
              default: ;
            endcase
          end
        end
        S_SCHEME: begin
          fidx  <= '0;
          count <= '0;
          bidx  <= '0;
          rd_wait <= 2'd2;
          state <= S_LEN;
        end
        S_LEN: begin
          // wait for length read of frame fidx
          if (rd_wait != 0) begin
            rd_wait <= rd_wait - 1'b1;
          end else begin
            flen    <= lrdata;
            lowest  <= (lrdata >= LW'(5)) ? lrdata - LW'(4) : LW'(1);
            crc     <= sch.init;
            hit     <= 1'b0;
            bidx    <= '0;
            rd_wait <= 2'd1;
            state   <= S_BYTE;
          end
        end
        S_BYTE: begin
          // wait for byte bidx to read
          if (rd_wait != 0) begin
            rd_wait <= rd_wait - 1'b1;
          end else begin
            prev <= {prev[7:0], brdata};
            if (flen < LW'(3)) begin
              state <= S_FRAMEEND;
            end else if (bidx >= LW'(2) && bidx - 1'b1 >= lowest && bidx <= flen - 1'b1
                         && check_ok) begin
              // CRC over bidx-1 bytes matched check byte at bidx-1 (8-bit) or bytes at bidx-1, bidx (16-bit)
              hit   <= 1'b1;
              state <= S_FRAMEEND;
            end else if (bidx + 1'b1 >= flen) begin
              state <= S_FRAMEEND;
            end else begin
              if (bidx != '0) begin
                crc    <= crc ^ (sch.wide ? {prev[7:0], 8'h00} : {8'h00, prev[7:0]});
                bitcnt <= 4'd8;
                state  <= S_BIT;
              end else begin
                bidx    <= bidx + 1'b1;
                rd_wait <= 2'd1;
              end
            end
          end
        end
        S_BIT: begin
          crc    <= crc_step;
          bitcnt <= bitcnt - 1'b1;
          if (bitcnt == 4'd1) begin
            bidx    <= bidx + 1'b1;
            rd_wait <= 2'd1;
            state   <= S_BYTE;
          end
        end
        S_CHECK: state <= S_FRAMEEND;
        S_FRAMEEND: begin
          count <= cnt_n;
          if (!last_frame) begin
            fidx    <= fidx + 1'b1;
            rd_wait <= 2'd2;
            state   <= S_LEN;
          end else if (over_thr) begin
            status           <= ST_FOUND;
            scheme_index     <= sidx;
            found_polynomial <= sch.poly;
            frames_matched   <= 7'(cnt_n);
            state            <= S_IDLE;
          end else if (sidx == 3'(NumSchemes - 1)) begin
            status           <= ST_NONE;
            scheme_index     <= '0;
            found_polynomial <= '0;
            frames_matched   <= 7'(cnt_n);
            state            <= S_IDLE;
          end else begin
            sidx  <= sidx + 1'b1;
            state <= S_SCHEME;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: src/csd_checker.sv
// Port-level checker for the CRC scheme detector, bound to the top level.
// Depends on csd_pkg and crc_scheme_detector_assert.svh.
`include "crc_scheme_detector_assert.svh"
module csd_checker
  import csd_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic [1:0]  op,
  input logic        strobe,
  input logic [1:0]  status,
  input logic [2:0]  scheme_index,
  input logic [15:0] found_polynomial
);
  `CSD_ASSERT_NEXT(a_add_not_busy, clk, rst, start && !busy && op != OP_SEARCH, !busy && !strobe, "byte or clear word made block busy or strobe")
  `CSD_ASSERT_IMP(a_status_code, clk, rst, strobe, status == ST_FOUND || status == ST_NONE || status == ST_TOO_FEW, "bad status")
  `CSD_ASSERT_IMP(a_none_zero, clk, rst, strobe && status != ST_FOUND, scheme_index == 3'd0 && found_polynomial == 16'd0, "nonzero index without match")
  `CSD_ASSERT_IMP(a_found_poly, clk, rst, strobe && status == ST_FOUND, found_polynomial != 16'd0 && scheme_index < 3'd5, "match on invalid scheme")
endmodule

bind crc_scheme_detector csd_checker u_csd_checker (
  .clk, .rst, .start, .busy, .op, .strobe, .status, .scheme_index, .found_polynomial
);
